// ===== design/dfxa_pkg.sv =====
// Shared constants and types for the decimal fixed-point ALU.
package dfxa_pkg;

   localparam int FRAC_DIGITS = 12;
   localparam int CELL_COUNT  = 64;

   // Powers of ten up to the largest supported fraction width.
   localparam logic [63:0] POW10_TABLE [0:18] = '{
      64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
      64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000,
      64'd10000000000, 64'd100000000000, 64'd1000000000000,
      64'd10000000000000, 64'd100000000000000, 64'd1000000000000000,
      64'd10000000000000000, 64'd100000000000000000,
      64'd1000000000000000000
   };

   localparam logic [63:0] SCALE = POW10_TABLE[FRAC_DIGITS];

   localparam logic [1:0] CMD_MUL    = 2'd0;
   localparam logic [1:0] CMD_DIV    = 2'd1;
   localparam logic [1:0] CMD_RSTEP  = 2'd2;
   localparam logic [1:0] CMD_RPLACE = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_DIV0 = 2'd1;
   localparam logic [1:0] STAT_OVF  = 2'd2;

   // Sideband that rides along with each transaction.
   typedef struct packed {
      logic        valid;
      logic        neg;
      logic        zdiv;
      logic        rnd;
      logic        ovf;
   } side_type;

   // State held by one divider cell.
   typedef struct packed {
      side_type    side;
      logic [63:0] d;
      logic [63:0] rem;
      logic [63:0] nq;   // numerator bits still to shift in, quotient bits behind
   } cell_type;

endpackage

// ===== design/dfxa_div_cell.sv =====
// One restoring-division cell: retires one quotient bit per transaction.
module dfxa_div_cell
   import dfxa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  cell_type cell_i,
   output cell_type cell_o
);

   cell_type    cell_ff;
   cell_type    cell_in;
   logic [64:0] trial;
   logic        ge;

   assign trial = {cell_i.rem, cell_i.nq[63]};
   assign ge    = trial >= {1'b0, cell_i.d};

   always_comb begin
      cell_in      = cell_i;
      cell_in.rem  = ge ? 64'(trial - {1'b0, cell_i.d}) : trial[63:0];
      cell_in.nq   = {cell_i.nq[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.side.valid <= 1'b0;
      end else if (enable) begin
         cell_ff.side.valid <= cell_in.side.valid;
      end
      if (enable) begin
         cell_ff.side.neg  <= cell_in.side.neg;
         cell_ff.side.zdiv <= cell_in.side.zdiv;
         cell_ff.side.rnd  <= cell_in.side.rnd;
         cell_ff.side.ovf  <= cell_in.side.ovf;
         cell_ff.d         <= cell_in.d;
         cell_ff.rem       <= cell_in.rem;
         cell_ff.nq        <= cell_in.nq;
      end
   end

   assign cell_o = cell_ff;

endmodule

// ===== design/dfxa_mul64.sv =====
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
module dfxa_mul64
   import dfxa_pkg::*;
(
   input  logic          clock,
   input  logic          enable,
   input  logic [63:0]   x,
   input  logic [63:0]   y,
   output logic [127:0]  product
);

   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [63:0]  ll_in, lh_in, hl_in, hh_in;
   logic [127:0] product_ff, product_in;

   assign ll_in = x[31:0]  * y[31:0];
   assign lh_in = x[31:0]  * y[63:32];
   assign hl_in = x[63:32] * y[31:0];
   assign hh_in = x[63:32] * y[63:32];

   assign product_in = {64'd0, ll_ff}
                     + {32'd0, lh_ff, 32'd0}
                     + {32'd0, hl_ff, 32'd0}
                     + {hh_ff, 64'd0};

   always_ff @(posedge clock) begin
      if (enable) begin
         ll_ff      <= ll_in;
         lh_ff      <= lh_in;
         hl_ff      <= hl_in;
         hh_ff      <= hh_in;
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== design/decimal_fixed_point_alu_unit.sv =====
// Top level of the decimal fixed-point ALU (values scaled by 10^FRAC_DIGITS).
//
//  channel  | ports        | tdata (low bit first)            | tuser
//  ---------+--------------+----------------------------------+-------------
//  request  | req_t*       | a[63:0] b[63:0] places[3:0] pad  | cmd[1:0]
//  response | rsp_t*       | value[63:0]                      | status[1:0]
//
// One transaction enters per cycle while the output buffer has room. The accepting
// edge loads the operand stage; a request then passes two multiplier stages, 64
// divider cells (one quotient bit each), one rounding stage, two more multiplier
// stages and the write into a two-entry output buffer. The whole pipe advances
// while that buffer has room, so a request is taken even while a response waits.
// Reset clears valid bits and the buffer; payload registers are not reset.
module decimal_fixed_point_alu_unit
   import dfxa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [135:0]  req_tdata,   // a[63:0], b[127:64], places[131:128], zero pad
   input  logic [1:0]    req_tuser,   // cmd[1:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,   // value[63:0]
   output logic [1:0]    rsp_tuser    // status[1:0]
);

   logic        enable;
   logic [1:0]  cmd;
   logic [63:0] a, b;
   logic [3:0]  places;
   logic [63:0] mag_a, mag_b;

   assign cmd    = req_tuser;
   assign a      = req_tdata[63:0];
   assign b      = req_tdata[127:64];
   assign places = req_tdata[131:128];
   assign mag_a  = a[63] ? 64'(64'd0 - a) : a;
   assign mag_b  = b[63] ? 64'(64'd0 - b) : b;

   // ---- operand stage: pick multiplier operand and divisor per command ----
   side_type    p1_side_ff, p1_side_in;
   logic [63:0] p1_x_ff, p1_y_ff, p1_d_ff;
   logic [63:0] p1_y_in, p1_d_in;
   logic [4:0]  step_idx;

   assign step_idx = 5'(FRAC_DIGITS) - {1'b0, places};

   always_comb begin
      p1_side_in       = '0;
      p1_side_in.valid = req_tvalid & enable;
      p1_side_in.neg   = a[63];
      p1_y_in          = 64'd1;
      p1_d_in          = 64'd1;
      case (cmd)
         CMD_MUL: begin
            p1_side_in.neg = a[63] ^ b[63];
            p1_y_in        = mag_b;
            p1_d_in        = SCALE;
         end
         CMD_DIV: begin
            p1_side_in.neg  = a[63] ^ b[63];
            p1_side_in.zdiv = (b == 64'd0);
            p1_y_in         = SCALE;
            p1_d_in         = mag_b;
         end
         CMD_RSTEP: begin
            p1_side_in.zdiv = (b == 64'd0);
            p1_side_in.rnd  = 1'b1;
            p1_d_in         = mag_b;
         end
         CMD_RPLACE: begin
            // enough places: divide by one, which passes a through unchanged
            if ({1'b0, places} < 5'(FRAC_DIGITS)) begin
               p1_side_in.rnd = 1'b1;
               p1_d_in        = POW10_TABLE[step_idx];
            end
         end
         default: begin
            p1_d_in = 64'd1;
         end
      endcase
   end

   // ---- sideband delay matching the front multiplier ----
   side_type    p2_side_ff, p3_side_ff;
   logic [63:0] p2_d_ff, p3_d_ff;
   logic [127:0] num;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_side_ff.valid <= 1'b0;
         p2_side_ff.valid <= 1'b0;
         p3_side_ff.valid <= 1'b0;
      end else if (enable) begin
         p1_side_ff.valid <= p1_side_in.valid;
         p2_side_ff.valid <= p1_side_ff.valid;
         p3_side_ff.valid <= p2_side_ff.valid;
      end
      if (enable) begin
         p1_side_ff.neg  <= p1_side_in.neg;
         p1_side_ff.zdiv <= p1_side_in.zdiv;
         p1_side_ff.rnd  <= p1_side_in.rnd;
         p1_side_ff.ovf  <= p1_side_in.ovf;
         p1_x_ff         <= mag_a;
         p1_y_ff         <= p1_y_in;
         p1_d_ff         <= p1_d_in;
         p2_side_ff.neg  <= p1_side_ff.neg;
         p2_side_ff.zdiv <= p1_side_ff.zdiv;
         p2_side_ff.rnd  <= p1_side_ff.rnd;
         p2_side_ff.ovf  <= p1_side_ff.ovf;
         p2_d_ff         <= p1_d_ff;
         p3_side_ff.neg  <= p2_side_ff.neg;
         p3_side_ff.zdiv <= p2_side_ff.zdiv;
         p3_side_ff.rnd  <= p2_side_ff.rnd;
         p3_side_ff.ovf  <= p2_side_ff.ovf;
         p3_d_ff         <= p2_d_ff;
      end
   end

   dfxa_mul64 u_mul_front (
      .clock   (clock),
      .enable  (enable),
      .x       (p1_x_ff),
      .y       (p1_y_ff),
      .product (num)
   );

   // ---- divider chain ----
   // Quotient fits 64 bits only when the upper half of the numerator is below
   // the divisor; otherwise flag saturation and start from the upper half.
   cell_type chain [0:CELL_COUNT];
   cell_type head;

   always_comb begin
      head          = '0;
      head.side     = p3_side_ff;
      head.side.ovf = num[127:64] >= p3_d_ff;
      head.d        = p3_d_ff;
      head.rem      = num[127:64];
      head.nq       = num[63:0];
   end

   assign chain[0] = head;

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      dfxa_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (enable),
         .cell_i (chain[i]),
         .cell_o (chain[i+1])
      );
   end

   // ---- rounding stage: half away from zero on the magnitude ----
   cell_type    last;
   side_type    t1_side_ff, t2_side_ff, t3_side_ff;
   logic [63:0] t1_q_ff, t1_q_in, t1_m_ff, t1_m_in;
   logic        inc;
   logic [127:0] mag;

   assign last    = chain[CELL_COUNT];
   assign inc     = last.side.rnd & (last.rem >= 64'(last.d - last.rem));
   assign t1_q_in = 64'(last.nq + {63'd0, inc});
   assign t1_m_in = last.side.rnd ? last.d : 64'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_side_ff.valid <= 1'b0;
         t2_side_ff.valid <= 1'b0;
         t3_side_ff.valid <= 1'b0;
      end else if (enable) begin
         t1_side_ff.valid <= last.side.valid;
         t2_side_ff.valid <= t1_side_ff.valid;
         t3_side_ff.valid <= t2_side_ff.valid;
      end
      if (enable) begin
         t1_side_ff.neg  <= last.side.neg;
         t1_side_ff.zdiv <= last.side.zdiv;
         t1_side_ff.rnd  <= last.side.rnd;
         t1_side_ff.ovf  <= last.side.ovf;
         t1_q_ff         <= t1_q_in;
         t1_m_ff         <= t1_m_in;
         t2_side_ff.neg  <= t1_side_ff.neg;
         t2_side_ff.zdiv <= t1_side_ff.zdiv;
         t2_side_ff.rnd  <= t1_side_ff.rnd;
         t2_side_ff.ovf  <= t1_side_ff.ovf;
         t3_side_ff.neg  <= t2_side_ff.neg;
         t3_side_ff.zdiv <= t2_side_ff.zdiv;
         t3_side_ff.rnd  <= t2_side_ff.rnd;
         t3_side_ff.ovf  <= t2_side_ff.ovf;
      end
   end

   // multiply back by the step for rounding, by one otherwise
   dfxa_mul64 u_mul_back (
      .clock   (clock),
      .enable  (enable),
      .x       (t1_q_ff),
      .y       (t1_m_ff),
      .product (mag)
   );

   // ---- sign and saturation ----
   localparam logic [63:0] LIM = 64'h8000_0000_0000_0000;
   logic        fits;
   logic [63:0] res_value;
   logic [1:0]  res_status;

   assign fits = !t3_side_ff.ovf && (mag[127:64] == 64'd0)
              && ((mag[63:0] < LIM) || (t3_side_ff.neg && mag[63:0] == LIM));

   always_comb begin
      if (t3_side_ff.zdiv) begin
         res_value  = 64'd0;
         res_status = STAT_DIV0;
      end else if (fits) begin
         res_value  = t3_side_ff.neg ? 64'(64'd0 - mag[63:0]) : mag[63:0];
         res_status = STAT_OK;
      end else begin
         res_value  = t3_side_ff.neg ? LIM : 64'(LIM - 64'd1);
         res_status = STAT_OVF;
      end
   end

   // ---- two-entry output buffer ----
   logic [65:0] buf_ff [0:1];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign enable     = (count_ff != 2'd2);
   assign push       = enable & t3_side_ff.valid;
   assign pop        = rsp_tvalid & rsp_tready;
   assign wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in  = pop  ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in   = 2'(count_ff + {1'b0, push} - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         buf_ff[wr_ptr_ff] <= {res_status, res_value};
      end
   end

   assign req_tready = enable;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = buf_ff[rd_ptr_ff][63:0];
   assign rsp_tuser  = buf_ff[rd_ptr_ff][65:64];

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the decimal fixed-point ALU: random and directed transactions checked in order.
`timescale 1ns / 100ps

module tb_top
   import dfxa_pkg::*;
;

   // ---------------------------------------------------------------------
   // Result predictor and in-order store of expected responses
   // ---------------------------------------------------------------------
   class alu_scoreboard;
      logic [63:0] exp_value [$];
      logic [1:0]  exp_status [$];
      int          mismatches = 0;

      // Applies a sign to a 128-bit magnitude, saturating to 64 bits.
      function void sign_sat(input bit neg, input logic [127:0] mag,
                             output logic [63:0] v, output logic [1:0] st);
         logic [127:0] lim;
         lim = 128'd1 << 63;
         if (mag < lim || (neg && mag == lim)) begin
            v  = neg ? -mag[63:0] : mag[63:0];
            st = STAT_OK;
         end else begin
            v  = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            st = STAT_OVF;
         end
      endfunction

      function logic [63:0] abs64(input logic [63:0] x);
         return x[63] ? -x : x;
      endfunction

      // Rounds a to the nearest multiple of step, halves away from zero.
      function void round_to(input logic [63:0] a, input logic [63:0] step,
                             output logic [63:0] v, output logic [1:0] st);
         logic [63:0]  m, q, r;
         logic [127:0] prod;
         m = abs64(a);
         q = m / step;
         r = m % step;
         if (r >= step - r) q = q + 64'd1;
         prod = {64'd0, q} * {64'd0, step};
         sign_sat(a[63], prod, v, st);
      endfunction

      // Notes an accepted request and queues its expected response.
      function void note_request(input logic [1:0] cmd, input logic [63:0] a,
                                 input logic [63:0] b, input logic [3:0] places);
         logic [63:0]  v, p;
         logic [1:0]   st;
         logic [127:0] wide;
         int           k;
         v  = '0;
         st = STAT_OK;
         case (cmd)
            CMD_MUL: begin
               wide = ({64'd0, abs64(a)} * {64'd0, abs64(b)}) / {64'd0, SCALE};
               sign_sat(a[63] ^ b[63], wide, v, st);
            end
            CMD_DIV: begin
               if (b == 64'd0) st = STAT_DIV0;
               else begin
                  wide = ({64'd0, abs64(a)} * {64'd0, SCALE}) / {64'd0, abs64(b)};
                  sign_sat(a[63] ^ b[63], wide, v, st);
               end
            end
            CMD_RSTEP: begin
               if (b == 64'd0) st = STAT_DIV0;
               else round_to(a, abs64(b), v, st);
            end
            default: begin
               if (places >= FRAC_DIGITS) v = a;
               else begin
                  p = 64'd1;
                  for (k = 0; k < FRAC_DIGITS - places; k++) p = p * 64'd10;
                  round_to(a, p, v, st);
               end
            end
         endcase
         exp_value.push_back(v);
         exp_status.push_back(st);
      endfunction

      // Checks one accepted response against the oldest expectation.
      function void check_response(input logic [63:0] v, input logic [1:0] st);
         logic [63:0] ev;
         logic [1:0]  es;
         if (exp_value.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response value=%h status=%0d", v, st);
            return;
         end
         ev = exp_value.pop_front();
         es = exp_status.pop_front();
         if (v !== ev || st !== es) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                        ev, v, es, st);
         end
      endfunction

      function int pending();
         return exp_value.size();
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   localparam int LATENCY     = 70;
   localparam int RANDOM_REQS = 450;
   localparam int CYCLE_LIMIT = 200000;

   alu_scoreboard sb = new();
   int  cycles = 0;
   bit  quiet = 0;       // no idling in the closing stretch
   bit  long_hold = 0;   // receiver holds off for a long stretch

   always #6 clock = ~clock;

   decimal_fixed_point_alu_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Response side: check accepted transactions, stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
   end

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            // hold off long enough that the pipe fills and req_tready drops
            repeat (200) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Picks an operand biased toward interesting corners.
   function logic [63:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 64'h7fff_ffff_ffff_ffff;
         1: return 64'h8000_0000_0000_0000;
         2: return 64'd0;
         3: return {{32{$urandom_range(0, 1) == 1}}, $urandom()};
         4: return 64'(SCALE) * 64'($urandom_range(0, 1000)) + 64'($urandom_range(0, 3));
         5: return -(64'(SCALE) * 64'($urandom_range(0, 1000)));
         6: return 64'($signed($urandom_range(0, 2000)) - 1000);
         default: return rand64();
      endcase
   endfunction

   // Sends one request; holds it until the block takes it.
   task automatic send_request(input logic [1:0] cmd, input logic [63:0] a,
                               input logic [63:0] b, input logic [3:0] places);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, places, b, a};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, a, b, places);
   endtask

   // Lowers valid for a random burst, at random.
   task automatic sender_idle();
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      logic [63:0] a, b;
      logic [1:0]  cmd;
      logic [3:0]  pl;
      int          i;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, every command, zero divisor/step, overflow,
      // halves, negative step, places at and beyond the fraction width.
      send_request(CMD_MUL, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, '0);
      send_request(CMD_MUL, 64'h8000_0000_0000_0000, 64'(SCALE), '0);
      send_request(CMD_MUL, 64'h8000_0000_0000_0000, -64'(SCALE), '0);
      send_request(CMD_MUL, -64'd1500000000000, 64'd2000000000000, '0);
      send_request(CMD_MUL, 64'd1, 64'd1, '0);
      send_request(CMD_DIV, 64'd5, '0, '0);
      send_request(CMD_DIV, 64'h7fff_ffff_ffff_ffff, 64'd1, '0);
      send_request(CMD_DIV, 64'h8000_0000_0000_0000, -64'd1, '0);
      send_request(CMD_DIV, -64'd7000000000000, 64'd2000000000000, '0);
      send_request(CMD_RSTEP, 64'd25, '0, '0);
      send_request(CMD_RSTEP, 64'd25, 64'd10, '0);
      send_request(CMD_RSTEP, -64'd25, -64'd10, '0);
      send_request(CMD_RSTEP, 64'd4, 64'd10, '0);
      send_request(CMD_RSTEP, 64'h7fff_ffff_ffff_ffff, 64'h4000_0000_0000_0000, '0);
      send_request(CMD_RSTEP, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0);
      send_request(CMD_RPLACE, 64'd1234567890123, '0, 4'd2);
      send_request(CMD_RPLACE, -64'd1235000000000, '0, 4'd9);
      send_request(CMD_RPLACE, -64'd500000000000, '0, 4'd0);
      send_request(CMD_RPLACE, 64'h7fff_ffff_ffff_ffff, '0, 4'd0);
      send_request(CMD_RPLACE, 64'h8000_0000_0000_0000, '0, 4'd11);
      send_request(CMD_RPLACE, 64'h8000_0000_0000_0000, 64'hffff, 4'd12);
      send_request(CMD_RPLACE, 64'd123, 64'h1, 4'd15);

      // Pause until every expected response has come.
      wait_drained();

      for (i = 0; i < RANDOM_REQS; i++) begin
         if (i == 150) long_hold = 1;
         if (i == RANDOM_REQS - 60) quiet = 1;
         cmd = 2'($urandom_range(0, 3));
         a   = pick_operand();
         b   = ($urandom_range(0, 3) == 0) ? rand64() : pick_operand();
         pl  = 4'($urandom_range(0, 15));
         send_request(cmd, a, b, pl);
         sender_idle();
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
